### src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } sha_state_t;

    // where the sixteen block words of a compression come from
    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD,
        BLK_LEN
    } blk_mode_t;

    // control from the sequencer to the block memory
    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_addr;
        logic [31:0] wr_data;
        logic [3:0] rd_addr;
    } sched_ctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[i];
    endfunction

    function automatic logic [31:0] start_hash(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        start_hash = h[i];
    endfunction

endpackage

### src/sha_sched_mem.sv
// ----------------------------------------------------------------------------
// sha_sched_mem
// Sixteen-word block memory, one write and one registered read.
// ----------------------------------------------------------------------------
module sha_sched_mem (
    input  logic                aclk,
    input  sha_pkg::sched_ctl_t ctl,
    output logic [31:0]         rd_data
);
    import sha_pkg::*;

    logic [31:0] mem [16];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data <= mem[ctl.rd_addr];
    end
endmodule

### src/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Byte packing, padding, round sequencer and working variables.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_present,
    input  logic        in_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last
);
    import sha_pkg::*;

    sha_state_t  state_reg, state_next;
    blk_mode_t   mode_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [23:0] part_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        closing_reg;
    logic [31:0] sched_reg [16];
    logic [31:0] w_new;
    logic [31:0] w_cur;
    logic [31:0] blk_word;
    logic [31:0] pad_word;
    logic [31:0] rd_data;
    sched_ctl_t  ctl;
    logic [31:0] t1, t2;
    logic        acc;
    logic        len_fits;
    logic [3:0]  widx;
    logic [3:0]  pidx;
    logic [63:0] total;

    // block words live in the memory; sched_reg keeps the last sixteen schedule words
    sha_sched_mem u_mem (.aclk(aclk), .ctl(ctl), .rd_data(rd_data));

    assign acc = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign total = bits_reg + {55'd0, fill_reg, 3'd0};
    assign pidx = fill_reg[5:2];
    assign len_fits = (fill_reg < 6'd56);
    assign widx = rnd_reg[3:0];

    always_comb begin
        case (fill_reg[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'd0};
            2'd1: pad_word = {part_reg[7:0], PAD_BYTE, 16'd0};
            2'd2: pad_word = {part_reg[15:0], PAD_BYTE, 8'd0};
            default: pad_word = {part_reg, PAD_BYTE};
        endcase
    end

    // final blocks: pad word and length are put in place of the memory word
    always_comb begin
        blk_word = 32'd0;
        case (mode_reg)
            BLK_DATA: blk_word = rd_data;
            BLK_PAD: begin
                if (widx < pidx)
                    blk_word = rd_data;
                else if (widx == pidx)
                    blk_word = pad_word;
                else if (len_fits && widx == 4'd14)
                    blk_word = total[63:32];
                else if (len_fits && widx == 4'd15)
                    blk_word = total[31:0];
            end
            BLK_LEN: begin
                if (widx == 4'd14)
                    blk_word = total[63:32];
                else if (widx == 4'd15)
                    blk_word = total[31:0];
            end
            default: blk_word = 32'd0;
        endcase
    end

    always_comb begin
        w_new = rotr(sched_reg[14], 17) ^ rotr(sched_reg[14], 19) ^ (sched_reg[14] >> 10);
        w_new = w_new + sched_reg[9] + sched_reg[0]
              + (rotr(sched_reg[1], 7) ^ rotr(sched_reg[1], 18) ^ (sched_reg[1] >> 3));
        w_cur = (rnd_reg < 6'd16) ? blk_word : w_new;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_k(rnd_reg) + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // read runs one word ahead of the round that uses it
    always_comb begin
        ctl.wr_en   = acc && in_present && (fill_reg[1:0] == 2'd3);
        ctl.wr_addr = fill_reg[5:2];
        ctl.wr_data = {part_reg, in_byte};
        ctl.rd_addr = (state_reg == ST_ROUND) ? rnd_reg[3:0] + 4'd1 : 4'd0;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (acc && (in_end || (in_present && fill_reg == 6'd63)))
                         state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD: begin
                if (mode_reg == BLK_DATA)
                    state_next = closing_reg ? ST_LOAD : ST_IDLE;
                else if (mode_reg == BLK_PAD && !len_fits)
                    state_next = ST_LOAD;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:  if (out_ready && idx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid = (state_reg == ST_EMIT);
        out_word  = hash_reg[idx_reg];
        out_index = idx_reg;
        out_last  = (idx_reg == 3'd7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg <= BLK_DATA;
            fill_reg <= '0;
            bits_reg <= '0;
            closing_reg <= 1'b0;
            idx_reg <= '0;
            rnd_reg <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= start_hash(3'(i));
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: if (acc) begin
                    if (in_present) begin
                        if (fill_reg[1:0] == 2'd0)
                            part_reg <= {16'd0, in_byte};
                        else
                            part_reg <= {part_reg[15:0], in_byte};
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63) bits_reg <= bits_reg + 64'd512;
                    end
                    mode_reg <= (in_present && fill_reg == 6'd63) ? BLK_DATA : BLK_PAD;
                    closing_reg <= in_end;
                end
                ST_LOAD: begin
                    for (int i = 0; i < 8; i++) v_reg[i] <= hash_reg[i];
                    rnd_reg <= '0;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) sched_reg[i] <= sched_reg[i + 1];
                    sched_reg[15] <= w_cur;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + v_reg[i];
                    idx_reg <= '0;
                    if (mode_reg == BLK_DATA)
                        mode_reg <= BLK_PAD;
                    else if (mode_reg == BLK_PAD)
                        mode_reg <= BLK_LEN;
                end
                ST_EMIT: if (out_ready) begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        fill_reg <= '0;
                        bits_reg <= '0;
                        closing_reg <= 1'b0;
                        for (int i = 0; i < 8; i++) hash_reg[i] <= start_hash(3'(i));
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### src/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_axis  | in  | tdata = data_byte, tuser = byte_present, tlast = end_of_message
//  m_axis  | out | tdata = digest_word, tuser = word_index, tlast = last_word
//
//  bytes are taken one a cycle while the core is idle; every 64th byte holds
//  the input through one load state, 64 rounds at one a cycle and one fold state; a closing
//  transaction adds one or two such blocks plus eight output transactions.
//  reset restores the initial hash values.
//  output stalls hold the digest and the input stays not ready until drained.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    sha_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_byte(s_axis_tdata), .in_present(s_axis_tuser), .in_end(s_axis_tlast),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("input open during output");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("last flag mismatch");
endmodule

### dv/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both stream channels, hashes accepted bytes and checks each digest word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_words,
    output int          digests_seen
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    digest_beat_t expected_digest_q [$];

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, e, a;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = chain;
        for (int i = 0; i < 64; i++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + RK[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic restart_hash();
        chain = IV;
        fill = '0;
        bit_len = '0;
    endtask

    task automatic absorb_byte(logic [7:0] b, logic present, logic close);
        logic [63:0] total;
        digest_beat_t beat;
        if (present) begin
            blk[fill] = b;
            fill = fill + 6'd1;
            if (fill == 6'd0) begin
                fold_block();
                bit_len = bit_len + 64'd512;
            end
        end
        if (close) begin
            total = bit_len + 64'(fill) * 64'd8;
            blk[fill] = 8'h80;
            for (int i = int'(fill) + 1; i < 64; i++)
                blk[i] = 8'h00;
            if (fill >= 6'd56) begin
                fold_block();
                for (int i = 0; i < 56; i++)
                    blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = total[63-8*i -: 8];
            fold_block();
            for (int i = 0; i < 8; i++) begin
                beat.word = chain[i];
                beat.index = 3'(i);
                beat.last = (i == 7);
                expected_digest_q.push_back(beat);
            end
            restart_hash();
        end
    endtask

    always @(posedge aclk) begin
        digest_beat_t want;
        if (!aresetn) begin
            restart_hash();
            expected_digest_q.delete();
            fail_count = 0;
            digests_seen = 0;
            pending_words <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_digest_q.size() == 0) begin
                    $display("%0t: unexpected transaction expected none actual %h/%0d/%0d",
                             $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = expected_digest_q.pop_front();
                    if (want != {m_axis_tdata, m_axis_tuser, m_axis_tlast}) begin
                        $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
                                 $realtime, want.word, want.index, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tlast)
                        digests_seen++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            pending_words <= expected_digest_q.size();
        end
    end

endmodule

### dv/sha256_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Drives byte messages of many lengths with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count, pending_words, digests_seen;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          items_sent = 0;
    int          sink_phase = 0;

    sha256_stream_hasher uut (.*);
    sha256_digest_checker chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sink stalls: long ready runs alternating with random stall bursts
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        sink_phase <= (sink_phase + 1) % 97;
        if (sink_phase < 40)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 9) != 0);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", pending_words);
            $display("** sha256_stream_hasher: FAILED **");
            $finish;
        end
    end

    int burst_left = 0;

    // one transaction; gaps land between bursts
    task automatic send_item(logic [7:0] b, logic present, logic close);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            repeat ($urandom_range(0, 6)) @(posedge aclk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= present;
        s_axis_tlast <= close;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
        if (present) bytes_sent++;
        if (burst_left == 0 || $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // random message of n bytes, closed either with the last byte or separately
    task automatic send_message(int n);
        bit split_close;
        split_close = (n == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !split_close && (i == n - 1));
        end
        if (split_close)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, idle item, byte extremes, short messages
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b1);
        send_message(3);
        send_message(7);

        // random: lengths around block and padding edges, mostly short
        while (items_sent < 420) begin
            case ($urandom_range(0, 9))
                0: send_message(55 + $urandom_range(0, 2));
                1: send_message(63 + $urandom_range(0, 2));
                2: send_message(119 + $urandom_range(0, 2));
                3: send_message(0);
                default: send_message($urandom_range(1, 20));
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (pending_words != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("covered %0d transactions, %0d message bytes and %0d digests",
                 items_sent, bytes_sent, digests_seen);
        $display("block and padding edges included");
        if (fail_count == 0) begin
            $display("** sha256_stream_hasher: PASSED **");
        end else begin
            $display("** sha256_stream_hasher: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
src/sha_pkg.sv
src/sha_sched_mem.sv
src/sha_core.sv
src/sha256_stream_hasher.sv
dv/sha256_digest_checker.sv
dv/sha256_stream_hasher_tb.sv
